[src/mcd_pkg.sv]
`default_nettype none
package mcd_pkg;

  localparam int MCD_LENGTH_BITS = 24;

  // parser phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_COUNT   = 3'd1;
  localparam logic [2:0] PH_NAMELEN = 3'd2;
  localparam logic [2:0] PH_NAME    = 3'd3;
  localparam logic [2:0] PH_FLAG    = 3'd4;
  localparam logic [2:0] PH_CODELEN = 3'd5;
  localparam logic [2:0] PH_CODE    = 3'd6;
  localparam logic [2:0] PH_STOP    = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_CODE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [23:0] index;
    logic        flag;
    logic        last;
    logic        done;
  } res_t;

endpackage
`default_nettype wire

[src/mcd_step.sv]
`default_nettype none
module mcd_step
  import mcd_pkg::*;
#(
  parameter int LENGTH_BITS = MCD_LENGTH_BITS
) (
  input  wire logic [7:0]             data_byte,
  input  wire logic                   first_byte,
  input  wire logic [23:0]            buffer_length,
  input  wire logic [2:0]             phase,
  input  wire logic [1:0]             word_byte_count,
  input  wire logic [31:0]            word_accumulator,
  input  wire logic [LENGTH_BITS-1:0] bytes_remaining,
  input  wire logic [31:0]            records_left,
  input  wire logic [23:0]            current_record,
  input  wire logic [31:0]            field_bytes_left,
  input  wire logic                   entry_mark,
  output logic [2:0]                  phase_next,
  output logic [1:0]                  word_byte_count_next,
  output logic [31:0]                 word_accumulator_next,
  output logic [LENGTH_BITS-1:0]      bytes_remaining_next,
  output logic [31:0]                 records_left_next,
  output logic [23:0]                 current_record_next,
  output logic [31:0]                 field_bytes_left_next,
  output logic                        entry_mark_next,
  output res_t                        res
);

  localparam logic [LENGTH_BITS-1:0] LenFour = LENGTH_BITS'(4);
  localparam logic [LENGTH_BITS-1:0] LenOne  = LENGTH_BITS'(1);

  logic [31:0]            len_wide;
  logic [LENGTH_BITS-1:0] len_init;

  assign len_wide = {8'd0, buffer_length};
  assign len_init = len_wide[LENGTH_BITS-1:0];

  always_comb begin
    logic                   go;
    logic                   settle;
    logic [31:0]            value;
    logic [LENGTH_BITS-1:0] br;
    logic [2:0]             ph;
    ph     = phase;
    br     = bytes_remaining;
    go     = 1'b1;
    settle = 1'b0;
    value  = word_accumulator;
    word_byte_count_next  = word_byte_count;
    word_accumulator_next = word_accumulator;
    records_left_next     = records_left;
    current_record_next   = current_record;
    field_bytes_left_next = field_bytes_left;
    entry_mark_next       = entry_mark;
    res = '0;

    // restart on the first byte of a container
    if (first_byte) begin
      word_byte_count_next  = 2'd0;
      word_accumulator_next = 32'd0;
      records_left_next     = 32'd0;
      current_record_next   = 24'd0;
      field_bytes_left_next = 32'd0;
      entry_mark_next       = 1'b0;
      br = len_init;
      if (br < LenFour) begin
        ph = PH_STOP;
        go = 1'b0;
      end else begin
        ph = PH_COUNT;
      end
    end

    if (ph == PH_IDLE || ph == PH_STOP || br == '0) go = 1'b0;

    if (go) begin
      br = br - LenOne;
      unique case (ph)
        PH_COUNT, PH_NAMELEN, PH_CODELEN: begin
          value = word_accumulator_next
                  | (32'(data_byte) << {word_byte_count_next, 3'b000});
          if (word_byte_count_next != 2'd3) begin
            word_accumulator_next = value;
            word_byte_count_next  = word_byte_count_next + 2'd1;
          end else begin
            word_accumulator_next = 32'd0;
            word_byte_count_next  = 2'd0;
            if (ph == PH_COUNT) begin
              records_left_next = value;
              if (value == 32'd0) begin
                ph = PH_STOP;
              end else begin
                ph = PH_NAMELEN;
                settle = 1'b1;
              end
            end else if (value > 32'(br)) begin
              // length runs past the container
              res.valid = 1'b1;
              res.kind  = KIND_TRUNC;
              res.index = current_record_next;
              res.done  = 1'b1;
              ph = PH_STOP;
            end else begin
              field_bytes_left_next = value;
              ph = (ph == PH_NAMELEN) ? PH_NAME : PH_CODE;
              settle = 1'b1;
            end
          end
        end
        PH_NAME, PH_CODE: begin
          res.valid = 1'b1;
          res.kind  = (ph == PH_NAME) ? KIND_NAME : KIND_CODE;
          res.data  = data_byte;
          res.index = current_record_next;
          res.flag  = (ph == PH_NAME) ? 1'b0 : entry_mark_next;
          if (field_bytes_left_next != 32'd0)
            field_bytes_left_next = field_bytes_left_next - 32'd1;
          settle = 1'b1;
        end
        PH_FLAG: begin
          entry_mark_next = (data_byte != 8'd0);
          ph = PH_CODELEN;
          settle = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // transitions that take no byte; two passes cover the longest chain
    if (settle) begin
      for (int p = 0; p < 2; p++) begin
        if (ph == PH_NAMELEN && br < LenFour) begin
          field_bytes_left_next = 32'd0;
          ph = PH_NAME;
        end
        if (ph == PH_NAME && field_bytes_left_next == 32'd0) ph = PH_FLAG;
        if (ph == PH_FLAG && br == '0) begin
          ph = PH_STOP;
          res.done = 1'b1;
        end
        if (ph == PH_CODELEN && br < LenFour) begin
          field_bytes_left_next = 32'd0;
          ph = PH_CODE;
        end
        if (ph == PH_CODE && field_bytes_left_next == 32'd0) begin
          if (!res.valid) begin
            res.valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.data  = 8'd0;
            res.index = current_record_next;
            res.flag  = entry_mark_next;
          end
          res.last = 1'b1;
          current_record_next = current_record_next + 24'd1;
          records_left_next   = records_left_next - 32'd1;
          if (records_left_next == 32'd0) begin
            ph = PH_STOP;
            res.done = 1'b1;
          end else begin
            ph = PH_NAMELEN;
          end
        end
      end
    end

    phase_next           = ph;
    bytes_remaining_next = br;
  end

endmodule
`default_nettype wire

[src/module_container_deframer.sv]
// a taken byte is held in the input register; any result it gives goes to the result register
// throughput: one byte per cycle while results drain; bytes with no result still pass through
// the per-byte counter update in the step logic is the only loop, closed through the state registers
// reset: synchronous, active high; parser returns to idle, all counters cleared, both stages empty
`default_nettype none
module module_container_deframer
  import mcd_pkg::*;
#(
  parameter int LENGTH_BITS = MCD_LENGTH_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // data_byte [7:0], buffer_length [31:8]
  input  wire logic        s_tuser,   // first_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_byte [7:0], record_index [31:8], entry_flag [32],
                                      // parse_done [33], zero [39:34]
  output logic [1:0]       m_tuser,   // kind
  output logic             m_tlast    // record_end
);

  // input register stage
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_first;
  logic [23:0] in_len;

  // parser state
  logic [2:0]             phase;
  logic [1:0]             word_byte_count;
  logic [31:0]            word_accumulator;
  logic [LENGTH_BITS-1:0] bytes_remaining;
  logic [31:0]            records_left;
  logic [23:0]            current_record;
  logic [31:0]            field_bytes_left;
  logic                   entry_mark;

  logic [2:0]             phase_next;
  logic [1:0]             word_byte_count_next;
  logic [31:0]            word_accumulator_next;
  logic [LENGTH_BITS-1:0] bytes_remaining_next;
  logic [31:0]            records_left_next;
  logic [23:0]            current_record_next;
  logic [31:0]            field_bytes_left_next;
  logic                   entry_mark_next;
  res_t                   res;

  logic advance;

  // the held byte moves on whenever the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata[7:0];
      in_len   <= s_tdata[31:8];
      in_first <= s_tuser;
    end
  end

  mcd_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .data_byte             (in_byte),
    .first_byte            (in_first),
    .buffer_length         (in_len),
    .phase                 (phase),
    .word_byte_count       (word_byte_count),
    .word_accumulator      (word_accumulator),
    .bytes_remaining       (bytes_remaining),
    .records_left          (records_left),
    .current_record        (current_record),
    .field_bytes_left      (field_bytes_left),
    .entry_mark            (entry_mark),
    .phase_next            (phase_next),
    .word_byte_count_next  (word_byte_count_next),
    .word_accumulator_next (word_accumulator_next),
    .bytes_remaining_next  (bytes_remaining_next),
    .records_left_next     (records_left_next),
    .current_record_next   (current_record_next),
    .field_bytes_left_next (field_bytes_left_next),
    .entry_mark_next       (entry_mark_next),
    .res                   (res)
  );

  // state only changes when a byte leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      word_byte_count  <= 2'd0;
      word_accumulator <= 32'd0;
      bytes_remaining  <= '0;
      records_left     <= 32'd0;
      current_record   <= 24'd0;
      field_bytes_left <= 32'd0;
      entry_mark       <= 1'b0;
    end else if (advance) begin
      phase            <= phase_next;
      word_byte_count  <= word_byte_count_next;
      word_accumulator <= word_accumulator_next;
      bytes_remaining  <= bytes_remaining_next;
      records_left     <= records_left_next;
      current_record   <= current_record_next;
      field_bytes_left <= field_bytes_left_next;
      entry_mark       <= entry_mark_next;
    end
  end

  // result register: drained by the downstream side, loaded only by bytes with a result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {6'd0, res.done, res.flag, res.index, res.data};
      m_tuser <= res.kind;
      m_tlast <= res.last;
    end
  end

endmodule
`default_nettype wire

[sim/module_container_deframer_test.sv]
`timescale 1ns / 100ps
module module_container_deframer_test;
  import mcd_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no request moving on either side
  localparam int DRAIN_CYCLES = 8;     // drain margin past the two-stage latency

  // one deframed result as the block reports it
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [23:0] rec;
    logic        flag;
    logic        rec_end;
    logic        done;
  } deframed_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // data_byte [7:0], buffer_length [31:8]
  logic        s_tuser;   // first_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // out_byte [7:0], record_index [31:8], entry_flag [32],
                          // parse_done [33], zero [39:34]
  logic [1:0]  m_tuser;   // kind
  logic        m_tlast;   // record_end

  module_container_deframer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mirror of the parser state
  logic [2:0]  ph;
  logic [1:0]  wcnt;
  logic [31:0] wacc;
  logic [23:0] left_bytes;
  logic [31:0] recs_left;
  logic [23:0] rec_no;
  logic [31:0] field_left;
  logic        entry_bit;

  // result of the byte being parsed
  deframed_t step_res;
  bit        step_hit;

  deframed_t  awaited_results[$];
  logic [7:0] frame_bytes[$];
  int         bytes_parsed;
  int         failures;
  bit         send_gaps   = 1'b1;
  bit         sink_stalls = 1'b1;

  function automatic void reset_parser();
    ph         = PH_IDLE;
    wcnt       = '0;
    wacc       = '0;
    left_bytes = '0;
    recs_left  = '0;
    rec_no     = '0;
    field_left = '0;
    entry_bit  = 1'b0;
  endfunction

  // walk every phase change that needs no byte
  function automatic void settle_fields();
    bit more;
    more = 1'b1;
    while (more) begin
      more = 1'b0;
      case (ph)
        PH_NAMELEN, PH_CODELEN: begin
          // a length word with under four bytes left reads as zero
          if (left_bytes < 4) begin
            field_left = '0;
            ph = (ph == PH_NAMELEN) ? PH_NAME : PH_CODE;
            more = 1'b1;
          end
        end
        PH_NAME: begin
          if (field_left == 0) begin
            ph = PH_FLAG;
            more = 1'b1;
          end
        end
        PH_FLAG: begin
          // no byte left for the entry flag: stop
          if (left_bytes == 0) begin
            ph = PH_STOP;
            step_res.done = 1'b1;
          end
        end
        PH_CODE: begin
          if (field_left == 0) begin
            if (!step_hit) begin
              // record with empty code
              step_hit       = 1'b1;
              step_res.kind  = KIND_EMPTY;
              step_res.value = '0;
              step_res.rec   = rec_no;
              step_res.flag  = entry_bit;
            end
            step_res.rec_end = 1'b1;
            rec_no    = rec_no + 24'd1;
            recs_left = recs_left - 32'd1;
            if (recs_left == 0) begin
              ph = PH_STOP;
              step_res.done = 1'b1;
            end else begin
              ph = PH_NAMELEN;
              more = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  endfunction

  // parse one container byte; returns 1 when the byte was not ignored
  function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                    input logic [23:0] len);
    logic [31:0] word;
    step_res = '0;
    step_hit = 1'b0;
    if (first) begin
      reset_parser();
      left_bytes = len;
      if (len < 4) begin
        ph = PH_STOP;
        return 1'b0;
      end
      ph = PH_COUNT;
    end
    if (ph == PH_IDLE || ph == PH_STOP || left_bytes == 0) return 1'b0;
    left_bytes = left_bytes - 24'd1;
    case (ph)
      PH_COUNT, PH_NAMELEN, PH_CODELEN: begin
        word = wacc | ({24'd0, b} << (8 * wcnt));
        if (wcnt < 3) begin
          wacc = word;
          wcnt = wcnt + 2'd1;
        end else begin
          wacc = '0;
          wcnt = '0;
          if (ph == PH_COUNT) begin
            recs_left = word;
            if (word == 0) begin
              ph = PH_STOP;
            end else begin
              ph = PH_NAMELEN;
              settle_fields();
            end
          end else if (word > {8'd0, left_bytes}) begin
            // length runs past the container
            step_hit     = 1'b1;
            step_res.kind = KIND_TRUNC;
            step_res.rec  = rec_no;
            step_res.done = 1'b1;
            ph = PH_STOP;
          end else begin
            field_left = word;
            ph = (ph == PH_NAMELEN) ? PH_NAME : PH_CODE;
            settle_fields();
          end
        end
      end
      PH_NAME, PH_CODE: begin
        step_hit       = 1'b1;
        step_res.kind  = (ph == PH_NAME) ? KIND_NAME : KIND_CODE;
        step_res.value = b;
        step_res.rec   = rec_no;
        step_res.flag  = (ph == PH_NAME) ? 1'b0 : entry_bit;
        if (field_left != 0) field_left = field_left - 32'd1;
        settle_fields();
      end
      PH_FLAG: begin
        entry_bit = (b != 8'd0);
        ph = PH_CODELEN;
        settle_fields();
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // one byte onto the end of the frame under construction
  function automatic void append_byte(input logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endfunction

  // little-endian 32-bit word into the frame under construction
  function automatic void add_word(input logic [31:0] w);
    append_byte(w[7:0]);
    append_byte(w[15:8]);
    append_byte(w[23:16]);
    append_byte(w[31:24]);
  endfunction

  // one request, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic first, input logic [23:0] len);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {len, b};
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    if (parse_byte(b, first, len)) bytes_parsed++;
    if (step_hit) awaited_results = {awaited_results, step_res};
  endtask

  // first n_send bytes of the frame; length only means something on the first
  task automatic send_frame(input logic [23:0] blen, input int n_send);
    for (int i = 0; i < n_send; i++)
      send_byte(frame_bytes[i], i == 0, (i == 0) ? blen : 24'($urandom));
  endtask

  // idle parser, empty container, zero record count, stopped parser
  task automatic test_ignored_bytes();
    send_byte(8'hA5, 1'b0, 24'hFFFFFF);
    frame_bytes.delete();
    append_byte(8'hFF);
    send_frame(24'd0, 1);
    frame_bytes.delete();
    add_word(32'd0);
    send_frame(24'd4, 4);
    send_byte(8'h33, 1'b0, 24'd0);
  endtask

  // name length and code length both read as zero, then one byte after the stop
  task automatic test_short_length_word();
    frame_bytes.delete();
    add_word(32'd1);
    append_byte(8'hFF);
    append_byte(8'h77);
    send_frame(24'd6, 6);
  endtask

  // full record at the largest size, then a name length beyond the container
  task automatic test_record_and_truncation();
    frame_bytes.delete();
    add_word(32'hFFFF_FFFF);
    add_word(32'd1);
    append_byte(8'h00);
    append_byte(8'h00);
    add_word(32'd2);
    append_byte(8'hAB);
    append_byte(8'hFF);
    add_word(32'hFFFF_FFFF);
    send_frame(24'hFFFFFF, frame_bytes.size());
  endtask

  // container ends before the entry flag, one byte past the end
  task automatic test_missing_flag();
    frame_bytes.delete();
    add_word(32'd1);
    add_word(32'd1);
    append_byte(8'h5A);
    append_byte(8'h11);
    send_frame(24'd9, 10);
  endtask

  // containers with random content, well-formed or broken or noisy in various ways
  task automatic test_random_containers(input int target, input bit with_idling);
    int          start;
    int          n_rec;
    int          nlen;
    int          clen;
    int          shape;
    int          n_send;
    logic [23:0] blen;
    logic [31:0] w;
    start = bytes_parsed;
    while (bytes_parsed - start < target) begin
      send_gaps   = with_idling && $urandom_range(0, 3) != 0;
      sink_stalls = with_idling && $urandom_range(0, 3) != 0;
      shape = $urandom_range(0, 15);
      frame_bytes.delete();
      if (shape == 0) begin
        // stray bytes outside any container
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 24'($urandom));
      end else begin
        n_rec = $urandom_range(1, 3);
        case (shape)
          1: add_word(32'd0);
          2: add_word($urandom);
          default: add_word(n_rec);
        endcase
        for (int r = 0; r < n_rec; r++) begin
          nlen = $urandom_range(0, 5);
          clen = $urandom_range(0, 5);
          w = nlen;
          if (shape == 3 && $urandom_range(0, 1) == 0)
            w = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 12);
          add_word(w);
          repeat (nlen) append_byte(8'($urandom));
          append_byte($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255)));
          w = clen;
          if (shape == 3 && $urandom_range(0, 1) == 0)
            w = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 12);
          add_word(w);
          repeat (clen) append_byte(8'($urandom));
        end
        blen   = 24'(frame_bytes.size());
        n_send = frame_bytes.size();
        case (shape)
          4: blen = 24'($urandom_range(0, frame_bytes.size() - 1));
          5: begin
            // trailing bytes past the declared size
            repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
            n_send = frame_bytes.size();
          end
          6: blen = 24'($urandom);
          7: begin
            blen   = 24'($urandom_range(0, 3));
            n_send = $urandom_range(1, 4);
          end
          8: n_send = $urandom_range(1, frame_bytes.size() - 1);
          default: ;
        endcase
        send_frame(blen, n_send);
      end
    end
  endtask

  // receiver back-pressure in random bursts
  initial begin : sink_pacing
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
    end
  endfunction

  // every result taken is held against the oldest one awaited
  always @(posedge clk) begin : check_results
    deframed_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, got kind %0d byte %h record %0d",
                 $time, m_tuser, m_tdata[7:0], m_tdata[31:8]);
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_tuser));
        check_field("out_byte", 32'(want.value), 32'(m_tdata[7:0]));
        check_field("record_index", 32'(want.rec), 32'(m_tdata[31:8]));
        check_field("entry_flag", 32'(want.flag), 32'(m_tdata[32]));
        check_field("record_end", 32'(want.rec_end), 32'(m_tlast));
        check_field("parse_done", 32'(want.done), 32'(m_tdata[33]));
        check_field("tdata padding", 32'd0, 32'(m_tdata[39:34]));
      end
    end
  end

  // ends the run once nothing has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("** module_container_deframer: FAILED **");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    reset_parser();
    bytes_parsed = 0;
    failures     = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_ignored_bytes();
    test_short_length_word();
    test_record_and_truncation();
    test_missing_flag();
    test_random_containers(300, 1'b1);
    // closing stretch at full rate on both sides
    test_random_containers(50, 1'b0);

    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("** module_container_deframer: PASSED **");
    end else begin
      $display("** module_container_deframer: FAILED **");
    end
    $finish;
  end

endmodule
